// ----- rtl/fcr_pkg.sv -----
package fcr_pkg;

  // table geometry
  localparam int LINE_WAYS     = 16;
  localparam int CACHE_ENTRIES = 4096;
  localparam int WAY_W         = $clog2(LINE_WAYS);
  localparam int IDX_W         = $clog2(CACHE_ENTRIES);
  localparam int CNT_W         = WAY_W + 1;

  // field widths
  localparam int HASH_W  = 64;
  localparam int TIME_W  = 32;
  localparam int TF_W    = 8;
  localparam int FLAG_W  = 17;
  localparam int PKT_W   = 32;
  localparam int TO_W    = 20;
  localparam int INS_W   = 4;
  localparam int RSN_W   = 3;
  localparam int CIDX_W  = 2;
  localparam int IN_DW   = 112;
  localparam int OUT_DW  = 184;

  // TCP flag masks
  localparam logic [TF_W-1:0] SYN_BIT  = 8'h02;
  localparam logic [TF_W-1:0] EOF_BITS = 8'h05;

  // end reasons
  localparam logic [RSN_W-1:0] RSN_IDLE   = 3'd0;
  localparam logic [RSN_W-1:0] RSN_ACTIVE = 3'd1;
  localparam logic [RSN_W-1:0] RSN_EOF    = 3'd2;
  localparam logic [RSN_W-1:0] RSN_SYN    = 3'd3;
  localparam logic [RSN_W-1:0] RSN_FULL   = 3'd4;

  // configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_INACTIVE = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_ACTIVE   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_INSERT   = 2'd2;

  // result kinds and request types
  localparam logic KIND_EXPORT = 1'b0;
  localparam logic KIND_DONE   = 1'b1;
  localparam logic REQ_SCAN    = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] last;
    logic [FLAG_W-1:0] flags;
    logic [PKT_W-1:0]  packets;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_SEARCH,
    ST_PLACE,
    ST_EVICT,
    ST_CHECK,
    ST_WB,
    ST_FINISH
  } fcr_state_t;

  typedef struct packed {
    logic idle_exp;
    logic active_exp;
  } age_t;

endpackage

// ----- rtl/fcr_ram.sv -----
module fcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/fcr_age_chk.sv -----
module fcr_age_chk (
  input  logic [fcr_pkg::TIME_W-1:0] ts,
  input  logic [fcr_pkg::TIME_W-1:0] first_time,
  input  logic [fcr_pkg::TIME_W-1:0] last_time,
  input  logic [fcr_pkg::TO_W-1:0]   inactive_timeout,
  input  logic [fcr_pkg::TO_W-1:0]   active_timeout,
  output fcr_pkg::age_t              age
);

  logic [fcr_pkg::TIME_W:0] idle_diff;
  logic [fcr_pkg::TIME_W:0] act_diff;

  // a negative difference (borrow set) never expires
  assign idle_diff = {1'b0, ts} - {1'b0, last_time};
  assign act_diff  = {1'b0, ts} - {1'b0, first_time};

  assign age.idle_exp = !idle_diff[fcr_pkg::TIME_W] &&
    (idle_diff[fcr_pkg::TIME_W-1:0] >= fcr_pkg::TIME_W'(inactive_timeout));
  assign age.active_exp = !act_diff[fcr_pkg::TIME_W] &&
    (act_diff[fcr_pkg::TIME_W-1:0] >= fcr_pkg::TIME_W'(active_timeout));

endmodule

// ----- rtl/flow_cache_line_replacement_unit.sv -----
// Sequence: a packet loads its line from the table, makes up to three search or
// placement passes, writes the line back and emits a completion; a scan tick
// loads, scans and writes back its line and emits a completion. A new item is
// taken only in the idle state, since the single line buffer and the one table
// port serve one item at a time. Reset: synchronous, active low; afterwards a
// pass clears every entry while input is held off.
module flow_cache_line_replacement_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // tdata: flow_hash_in, timestamp_seconds, tcp_flags_in, key_swapped, zero pad
  input  logic [fcr_pkg::IN_DW-1:0]     in_tdata,
  // tuser: req_type
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // tdata: slot_index, flow_hash_out, end_reason, first_seen, last_seen,
  //        packet_total, seen_tcp_flags, hit
  output logic [fcr_pkg::OUT_DW-1:0]    out_tdata,
  // tuser: result_kind
  output logic                          out_tuser,
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fcr_pkg::CIDX_W-1:0]    cfg_index,
  input  logic [fcr_pkg::TO_W-1:0]      cfg_data
);

  localparam logic [fcr_pkg::WAY_W-1:0] LAST_WAY = fcr_pkg::WAY_W'(fcr_pkg::LINE_WAYS - 1);
  localparam logic [fcr_pkg::CNT_W-1:0] CNT_FULL = fcr_pkg::CNT_W'(fcr_pkg::LINE_WAYS);
  localparam logic [fcr_pkg::IDX_W-1:0] CLR_LAST =
    fcr_pkg::IDX_W'(fcr_pkg::CACHE_ENTRIES - 1);

  fcr_pkg::fcr_state_t state_r, state_nxt;

  // configuration
  logic [fcr_pkg::TO_W-1:0]  inact_r, act_r;
  logic [fcr_pkg::INS_W-1:0] ins_r;

  // request context
  logic [fcr_pkg::IDX_W-1:0]  base_r, base_nxt;
  logic [fcr_pkg::HASH_W-1:0] hash_r, hash_nxt;
  logic [fcr_pkg::TIME_W-1:0] ts_r, ts_nxt;
  logic [fcr_pkg::TF_W-1:0]   tf_r, tf_nxt;
  logic                       sw_r, sw_nxt;
  logic                       tick_r, tick_nxt;
  logic [fcr_pkg::IDX_W-1:0]  scan_ptr_r, scan_ptr_nxt;

  // sequencer
  logic [fcr_pkg::WAY_W-1:0] idx_r, idx_nxt;
  logic [fcr_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [fcr_pkg::IDX_W-1:0] clr_r, clr_nxt;
  logic [1:0]                pass_r, pass_nxt;
  logic                      src_r, src_nxt;
  logic                      hit_r, hit_nxt;
  logic                      mode_r, mode_nxt;

  fcr_pkg::entry_t line_r   [fcr_pkg::LINE_WAYS];
  fcr_pkg::entry_t line_nxt [fcr_pkg::LINE_WAYS];

  // output register
  logic                        out_valid_r;
  logic [fcr_pkg::OUT_DW-1:0]  out_data_r;
  logic                        out_kind_r;
  logic                        out_last_r;

  // ram port
  logic                         ram_we;
  logic [fcr_pkg::IDX_W-1:0]    ram_waddr, ram_raddr;
  logic [fcr_pkg::ENTRY_W-1:0]  ram_wdata, ram_rdata;

  // shared datapath
  fcr_pkg::entry_t             cur;
  fcr_pkg::age_t               age;
  logic                        expired, hit_match, syn_eof, out_free;
  logic [fcr_pkg::TF_W-1:0]    both, dflags;
  logic [fcr_pkg::RSN_W-1:0]   rsn_to, rsn_idle;
  logic [fcr_pkg::WAY_W-1:0]   pos;
  logic [fcr_pkg::IDX_W-1:0]   cur_slot;

  // emission
  logic                        em_en, em_kind, em_hit;
  logic [fcr_pkg::IDX_W-1:0]   em_slot;
  logic [fcr_pkg::HASH_W-1:0]  em_hash;
  logic [fcr_pkg::RSN_W-1:0]   em_rsn;
  logic [fcr_pkg::TIME_W-1:0]  em_fs, em_ls;
  logic [fcr_pkg::PKT_W-1:0]   em_pk;
  logic [fcr_pkg::TF_W-1:0]    em_fl;

  fcr_ram #(
    .WIDTH(fcr_pkg::ENTRY_W),
    .DEPTH(fcr_pkg::CACHE_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign cur = line_r[idx_r];

  fcr_age_chk u_age (
    .ts              (ts_r),
    .first_time      (cur.first),
    .last_time       (cur.last),
    .inactive_timeout(inact_r),
    .active_timeout  (act_r),
    .age             (age)
  );

  // decode the entry under the way pointer
  always_comb begin
    both      = cur.flags[7:0] | cur.flags[15:8];
    dflags    = src_r ? cur.flags[7:0] : cur.flags[15:8];
    expired   = age.idle_exp || age.active_exp;
    hit_match = cur.valid && (cur.hash == hash_r);
    syn_eof   = (|(tf_r & fcr_pkg::SYN_BIT)) && (|(dflags & fcr_pkg::EOF_BITS));
    rsn_idle  = (|(both & fcr_pkg::EOF_BITS)) ? fcr_pkg::RSN_EOF : fcr_pkg::RSN_IDLE;
    rsn_to    = age.idle_exp ? rsn_idle : fcr_pkg::RSN_ACTIVE;
    out_free  = !out_valid_r || out_tready;
    cur_slot  = base_r + fcr_pkg::IDX_W'(idx_r);
    if (32'(ins_r) >= fcr_pkg::LINE_WAYS) begin
      pos = LAST_WAY;
    end else begin
      pos = fcr_pkg::WAY_W'(ins_r);
    end
  end

  assign in_tready = (state_r == fcr_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fcr_pkg::ST_CLEAR: begin
        if (clr_r == CLR_LAST) state_nxt = fcr_pkg::ST_IDLE;
      end
      fcr_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = fcr_pkg::ST_LOAD;
      end
      fcr_pkg::ST_LOAD: begin
        if (cnt_r == CNT_FULL) begin
          state_nxt = tick_r ? fcr_pkg::ST_SCAN : fcr_pkg::ST_SEARCH;
        end
      end
      fcr_pkg::ST_SCAN: begin
        if (out_free && idx_r == LAST_WAY) state_nxt = fcr_pkg::ST_WB;
      end
      fcr_pkg::ST_SEARCH: begin
        if (hit_match) state_nxt = fcr_pkg::ST_CHECK;
        else if (idx_r == LAST_WAY) state_nxt = fcr_pkg::ST_PLACE;
      end
      fcr_pkg::ST_PLACE: begin
        if (!cur.valid) state_nxt = fcr_pkg::ST_CHECK;
        else if (expired) begin
          if (out_free) state_nxt = fcr_pkg::ST_CHECK;
        end else if (idx_r == LAST_WAY) state_nxt = fcr_pkg::ST_EVICT;
      end
      fcr_pkg::ST_EVICT: begin
        if (out_free) state_nxt = fcr_pkg::ST_CHECK;
      end
      fcr_pkg::ST_CHECK: begin
        if (out_free) begin
          if (cur.valid && (syn_eof || expired)) begin
            state_nxt = (pass_r == 2'd2) ? fcr_pkg::ST_WB : fcr_pkg::ST_SEARCH;
          end else begin
            state_nxt = fcr_pkg::ST_WB;
          end
        end
      end
      fcr_pkg::ST_WB: begin
        if (cnt_r == fcr_pkg::CNT_W'(LAST_WAY)) state_nxt = fcr_pkg::ST_FINISH;
      end
      fcr_pkg::ST_FINISH: begin
        if (out_free) state_nxt = fcr_pkg::ST_IDLE;
      end
      default: state_nxt = fcr_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs of each state
  always_comb begin
    base_nxt     = base_r;
    hash_nxt     = hash_r;
    ts_nxt       = ts_r;
    tf_nxt       = tf_r;
    sw_nxt       = sw_r;
    tick_nxt     = tick_r;
    scan_ptr_nxt = scan_ptr_r;
    idx_nxt      = idx_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    pass_nxt     = pass_r;
    src_nxt      = src_r;
    hit_nxt      = hit_r;
    mode_nxt     = mode_r;
    line_nxt     = line_r;
    ram_we       = 1'b0;
    ram_waddr    = base_r + fcr_pkg::IDX_W'(cnt_r[fcr_pkg::WAY_W-1:0]);
    ram_wdata    = line_r[0];
    ram_raddr    = base_r + fcr_pkg::IDX_W'(cnt_r[fcr_pkg::WAY_W-1:0]);
    em_en        = 1'b0;
    em_kind      = fcr_pkg::KIND_EXPORT;
    em_slot      = cur_slot;
    em_hash      = cur.hash;
    em_rsn       = rsn_to;
    em_fs        = cur.first;
    em_ls        = cur.last;
    em_pk        = cur.packets;
    em_fl        = both;
    em_hit       = 1'b0;
    case (state_r)
      fcr_pkg::ST_CLEAR: begin
        // sweep the table clearing every entry
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
      end
      fcr_pkg::ST_IDLE: begin
        // latch the request and pick its line
        hash_nxt = in_tdata[63:0];
        ts_nxt   = in_tdata[95:64];
        tf_nxt   = in_tdata[103:96];
        sw_nxt   = in_tdata[104];
        tick_nxt = (in_tuser == fcr_pkg::REQ_SCAN);
        cnt_nxt  = '0;
        idx_nxt  = '0;
        pass_nxt = '0;
        src_nxt  = 1'b1;
        hit_nxt  = 1'b0;
        mode_nxt = 1'b0;
        if (in_tuser == fcr_pkg::REQ_SCAN) begin
          base_nxt = scan_ptr_r;
          if (in_tvalid) begin
            scan_ptr_nxt = scan_ptr_r + fcr_pkg::IDX_W'(fcr_pkg::LINE_WAYS);
          end
        end else begin
          base_nxt = {in_tdata[fcr_pkg::IDX_W-1:fcr_pkg::WAY_W], fcr_pkg::WAY_W'(0)};
        end
      end
      fcr_pkg::ST_LOAD: begin
        // shift the line in from the table, one way a cycle
        if (cnt_r != '0) begin
          for (int j = 0; j < fcr_pkg::LINE_WAYS - 1; j++) begin
            line_nxt[j] = line_r[j+1];
          end
          line_nxt[fcr_pkg::LINE_WAYS-1] = fcr_pkg::entry_t'(ram_rdata);
        end
        if (cnt_r == CNT_FULL) cnt_nxt = '0;
        else cnt_nxt = cnt_r + 1'b1;
      end
      fcr_pkg::ST_SCAN: begin
        // export idle flows of the scanned line
        if (out_free) begin
          em_rsn = rsn_idle;
          if (cur.valid && age.idle_exp) begin
            em_en                = 1'b1;
            line_nxt[idx_r].valid = 1'b0;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      fcr_pkg::ST_SEARCH: begin
        // on a hit move the flow to the front of the line
        if (hit_match) begin
          src_nxt     = (sw_r == cur.flags[16]);
          line_nxt[0] = cur;
          for (int j = 1; j < fcr_pkg::LINE_WAYS; j++) begin
            if (fcr_pkg::WAY_W'(j) <= idx_r) line_nxt[j] = line_r[j-1];
          end
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      fcr_pkg::ST_PLACE: begin
        // take the first empty or timed-out way
        if (cur.valid) begin
          if (expired) begin
            if (out_free) begin
              em_en                 = 1'b1;
              line_nxt[idx_r].valid = 1'b0;
            end
          end else if (idx_r != LAST_WAY) begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      fcr_pkg::ST_EVICT: begin
        // evict the tail and open the insert way
        em_rsn = fcr_pkg::RSN_FULL;
        if (out_free) begin
          em_en = 1'b1;
          for (int j = 0; j < fcr_pkg::LINE_WAYS; j++) begin
            if (fcr_pkg::WAY_W'(j) == pos) begin
              line_nxt[j]       = cur;
              line_nxt[j].valid = 1'b0;
            end else if (fcr_pkg::WAY_W'(j) > pos) begin
              line_nxt[j] = line_r[j-1];
            end
          end
          idx_nxt = pos;
        end
      end
      fcr_pkg::ST_CHECK: begin
        // update, create or export the flow at the chosen way
        if (out_free) begin
          if (cur.valid && (syn_eof || expired)) begin
            em_en                 = 1'b1;
            em_rsn                = syn_eof ? fcr_pkg::RSN_SYN : rsn_to;
            line_nxt[idx_r].valid = 1'b0;
            pass_nxt              = pass_r + 1'b1;
            src_nxt               = 1'b1;
            if (pass_r != 2'd2) idx_nxt = '0;
            cnt_nxt = '0;
          end else if (!cur.valid) begin
            line_nxt[idx_r].valid   = 1'b1;
            line_nxt[idx_r].hash    = hash_r;
            line_nxt[idx_r].first   = ts_r;
            line_nxt[idx_r].last    = ts_r;
            line_nxt[idx_r].flags   = {sw_r, 8'h00, tf_r};
            line_nxt[idx_r].packets = fcr_pkg::PKT_W'(1);
            hit_nxt                 = 1'b0;
            mode_nxt                = 1'b1;
            cnt_nxt                 = '0;
          end else begin
            line_nxt[idx_r].flags = src_r ? (cur.flags | {9'h000, tf_r})
                                          : (cur.flags | {1'b0, tf_r, 8'h00});
            line_nxt[idx_r].last  = ts_r;
            if (cur.packets != '1) line_nxt[idx_r].packets = cur.packets + 1'b1;
            hit_nxt  = 1'b1;
            mode_nxt = 1'b1;
            cnt_nxt  = '0;
          end
        end
      end
      fcr_pkg::ST_WB: begin
        // write the line back, rotating it round to its original order
        ram_we = 1'b1;
        for (int j = 0; j < fcr_pkg::LINE_WAYS - 1; j++) begin
          line_nxt[j] = line_r[j+1];
        end
        line_nxt[fcr_pkg::LINE_WAYS-1] = line_r[0];
        cnt_nxt = cnt_r + 1'b1;
      end
      fcr_pkg::ST_FINISH: begin
        // completion beat
        em_en   = out_free;
        em_kind = fcr_pkg::KIND_DONE;
        em_rsn  = fcr_pkg::RSN_IDLE;
        if (mode_r) begin
          em_hit = hit_r;
        end else begin
          em_slot = base_r;
          em_hash = tick_r ? '0 : hash_r;
          em_fs   = '0;
          em_ls   = '0;
          em_pk   = '0;
          em_fl   = '0;
        end
      end
      default: begin
        em_en = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fcr_pkg::ST_CLEAR;
      clr_r      <= '0;
      scan_ptr_r <= '0;
      inact_r    <= fcr_pkg::TO_W'(30);
      act_r      <= fcr_pkg::TO_W'(300);
      ins_r      <= fcr_pkg::INS_W'(8);
      out_valid_r <= 1'b0;
      idx_r      <= '0;
      cnt_r      <= '0;
      pass_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      idx_r      <= idx_nxt;
      cnt_r      <= cnt_nxt;
      pass_r     <= pass_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          fcr_pkg::CFG_INACTIVE: inact_r <= cfg_data;
          fcr_pkg::CFG_ACTIVE:   act_r   <= cfg_data;
          fcr_pkg::CFG_INSERT:   ins_r   <= cfg_data[fcr_pkg::INS_W-1:0];
          default: ;
        endcase
      end
      if (em_en) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    hash_r <= hash_nxt;
    ts_r   <= ts_nxt;
    tf_r   <= tf_nxt;
    sw_r   <= sw_nxt;
    tick_r <= tick_nxt;
    src_r  <= src_nxt;
    hit_r  <= hit_nxt;
    mode_r <= mode_nxt;
    line_r <= line_nxt;
    if (em_en) begin
      out_kind_r <= em_kind;
      out_last_r <= em_kind;
      out_data_r <= {em_hit, em_fl, em_pk, em_ls, em_fs, em_rsn, em_hash, em_slot};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule
